// ----- rtl/diurnal_fourier_temperature_unit_defines.svh -----
// Assertion macros shared by the diurnal Fourier temperature unit.
`ifndef DIURNAL_FOURIER_TEMPERATURE_UNIT_DEFINES_SVH
`define DIURNAL_FOURIER_TEMPERATURE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and silenced during reset.
`define DFT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and silenced during reset.
`define DFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dfc_pkg.sv -----
// Shared constants, types and the arctangent table of the diurnal temperature unit.
`default_nettype none

package dfc_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 24;

	localparam int TIME_W     = 17;
	localparam int MEAN_W     = 15;
	localparam int RANGE_W    = 14;
	localparam int TEMP_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam int TRIG_W     = 32;
	localparam int ANGLE_W    = 32;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MEAN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE = 2'd1;

	localparam logic [TIME_W-1:0] DAY_SECONDS = 17'd86400;
	// floor(2^42 / 675); 2^32 / 86400 = 2^25 / 675
	localparam logic [32:0] PHASE_RECIP = 33'd6515624460;
	localparam logic [10:0] PHASE_DIV   = 11'd675;

	localparam logic signed [31:0] PI_HALF_Q30     = 32'sd1686629713;
	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

	localparam logic signed [33:0] OFFSET_Q24    = -34'sd5505443;
	localparam logic signed [16:0] MEAN_GAIN_Q16 = 17'sd63303;
	localparam logic signed [15:0] HARM_C1_Q16   = -16'sd28509;
	localparam logic signed [15:0] HARM_S1_Q16   = -16'sd9472;
	localparam logic signed [15:0] HARM_C2_Q16   = 16'sd6550;
	localparam logic signed [15:0] HARM_S2_Q16   = 16'sd1606;

	typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_t;

	typedef struct packed {
		quad_t                      quad;
		logic signed [ANGLE_W-1:0]  z;
	} angle_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
	} trig_t;

	// atan(2^-i) in Q30 radians
	function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [4:0] idx);
		logic signed [ANGLE_W-1:0] v;
		case (idx)
			5'd0:    v = 32'sd843314856;
			5'd1:    v = 32'sd497837829;
			5'd2:    v = 32'sd263043836;
			5'd3:    v = 32'sd133525158;
			5'd4:    v = 32'sd67021686;
			5'd5:    v = 32'sd33543515;
			5'd6:    v = 32'sd16775850;
			5'd7:    v = 32'sd8388437;
			5'd8:    v = 32'sd4194282;
			5'd9:    v = 32'sd2097149;
			5'd10:   v = 32'sd1048575;
			5'd11:   v = 32'sd524287;
			5'd12:   v = 32'sd262143;
			5'd13:   v = 32'sd131071;
			5'd14:   v = 32'sd65535;
			5'd15:   v = 32'sd32767;
			5'd16:   v = 32'sd16383;
			5'd17:   v = 32'sd8191;
			5'd18:   v = 32'sd4095;
			5'd19:   v = 32'sd2047;
			5'd20:   v = 32'sd1023;
			5'd21:   v = 32'sd511;
			5'd22:   v = 32'sd255;
			5'd23:   v = 32'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/diurnal_fourier_temperature_unit.sv -----
// Top level of the diurnal Fourier temperature unit: phase, CORDIC, harmonic sum, output.
`default_nettype none

// Turns a time of day (seconds since midnight, values of a day or more wrap once) into
// a modelled surface temperature in signed Q8.8 degrees Celsius: a fixed offset, plus a
// fixed gain times the configured daily mean, plus the configured daily range times a
// two-harmonic series (24 h and 12 h periods) whose cosine and sine come from a
// pipelined CORDIC. The result is rounded half up and saturated to 16 bits. The unit is
// fully pipelined and takes one sample per clock while sample_stall is low. The CORDIC
// has 16 stages by default, and at most 24 stages are used. Behind the output
// register sits a one-entry skid register, so the pipeline keeps flowing while a
// finished result waits; sample_stall rises only once both hold a result, and then the
// whole pipeline holds without losing or repeating a transaction. The configuration
// port is always ready; write mean_temperature (index 0) and temperature_range (index 1)
// only while the unit is idle. Other indexes are ignored.

`include "diurnal_fourier_temperature_unit_defines.svh"

module diurnal_fourier_temperature_unit #(
	parameter int CORDIC_STAGES = dfc_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [dfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dfc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// sample channel
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire logic [dfc_pkg::TIME_W-1:0]        time_seconds,
	// result channel
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic signed [dfc_pkg::TEMP_W-1:0]      surface_temperature
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [dfc_pkg::MEAN_W-1:0]  mean_q;
	logic        [dfc_pkg::RANGE_W-1:0] range_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			range_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == dfc_pkg::REG_MEAN) begin
				mean_q <= signed'(cfg_data);
			end
			if (cfg_index == dfc_pkg::REG_RANGE) begin
				range_q <= cfg_data[dfc_pkg::RANGE_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Flow control: the pipeline advances unless the skid register is full
	// ------------------------------------------------------------------
	logic run;
	logic skid_vld_q;
	logic result_valid_q;
	logic take;

	assign run          = !skid_vld_q;
	assign sample_stall = skid_vld_q;
	assign take         = result_valid_q && !result_stall;

	// valid bits of the stages around the CORDIC
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic trig_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (run) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= trig_vld;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: wrap a time of a day or more back into the day
	// ------------------------------------------------------------------
	logic [dfc_pkg::TIME_W-1:0] t_s1;

	always_ff @(posedge clk) begin
		if (run) begin
			if (time_seconds >= dfc_pkg::DAY_SECONDS) begin
				t_s1 <= time_seconds - dfc_pkg::DAY_SECONDS;
			end else begin
				t_s1 <= time_seconds;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 2-3: phase = floor(t * 2^32 / 86400) = floor(t * 2^25 / 675).
	// The reciprocal product lands on the quotient or one below it; the
	// remainder (always under 2 * 675, so 11 bits suffice and the low bits
	// of t * 2^25 are zero) tells which, and one increment fixes it.
	// ------------------------------------------------------------------
	logic [49:0] prod_s2;
	logic [31:0] p1_s3;
	logic [31:0] q_est;
	logic [10:0] q_lo_mul;
	logic [10:0] q_rem;

	always_ff @(posedge clk) begin
		if (run) begin
			prod_s2 <= 50'(t_s1) * 50'(dfc_pkg::PHASE_RECIP);
		end
	end

	always_comb begin
		q_est    = prod_s2[48:17];
		q_lo_mul = 11'(22'(q_est[10:0]) * 22'(dfc_pkg::PHASE_DIV));
		q_rem    = 11'd0 - q_lo_mul;
	end

	always_ff @(posedge clk) begin
		if (run) begin
			p1_s3 <= q_est + 32'(q_rem >= dfc_pkg::PHASE_DIV);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: fundamental and second harmonic phases, quadrant split, and
	// residual turn fraction scaled to Q30 radians.
	// Shifting the phase by an eighth turn makes the residual just the low
	// 30 phase bits read as signed, and the quadrant the top two bits plus
	// bit 29.
	// ------------------------------------------------------------------
	logic [31:0]               ph [2];
	logic signed [29:0]        resid [2];
	logic signed [61:0]        zp_s4 [2];
	dfc_pkg::quad_t            quad_s4 [2];

	assign ph[0] = p1_s3;
	assign ph[1] = {p1_s3[30:0], 1'b0};

	for (genvar l = 0; l < 2; l++) begin : g_phase
		assign resid[l] = signed'(ph[l][29:0]);

		always_ff @(posedge clk) begin
			if (run) begin
				zp_s4[l]   <= 62'(resid[l]) * 62'(dfc_pkg::PI_HALF_Q30);
				quad_s4[l] <= dfc_pkg::quad_t'(ph[l][31:30] + {1'b0, ph[l][29]});
			end
		end
	end

	// truncate toward zero: round the floor shift up when negative and inexact
	dfc_pkg::angle_t [1:0] angle;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			angle[l].quad = quad_s4[l];
			angle[l].z    = dfc_pkg::ANGLE_W'(zp_s4[l] >>> 30);
			if (zp_s4[l][61] && (zp_s4[l][29:0] != '0)) begin
				angle[l].z = angle[l].z + 32'sd1;
			end
		end
	end

	// ------------------------------------------------------------------
	// CORDIC: both harmonics side by side
	// ------------------------------------------------------------------
	dfc_pkg::trig_t [1:0] trig;

	dfc_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (run),
		.in_vld  (v_s4),
		.angle   (angle),
		.out_vld (trig_vld),
		.trig    (trig)
	);

	// ------------------------------------------------------------------
	// Stages 5-7: harmonic sum h = round(sum(coef * trig) / 2^30), Q16
	// ------------------------------------------------------------------
	logic signed [47:0] hp_s5 [4];
	logic signed [48:0] hs_s6 [2];
	logic signed [49:0] hsum;
	logic signed [17:0] h_s7;

	always_ff @(posedge clk) begin
		if (run) begin
			hp_s5[0] <= 48'(dfc_pkg::HARM_C1_Q16) * 48'(trig[0].c);
			hp_s5[1] <= 48'(dfc_pkg::HARM_S1_Q16) * 48'(trig[0].s);
			hp_s5[2] <= 48'(dfc_pkg::HARM_C2_Q16) * 48'(trig[1].c);
			hp_s5[3] <= 48'(dfc_pkg::HARM_S2_Q16) * 48'(trig[1].s);
			hs_s6[0] <= 49'(hp_s5[0]) + 49'(hp_s5[1]);
			hs_s6[1] <= 49'(hp_s5[2]) + 49'(hp_s5[3]);
			h_s7     <= 18'(hsum >>> 30);
		end
	end

	assign hsum = 50'(hs_s6[0]) + 50'(hs_s6[1]) + 50'sd536870912;

	// ------------------------------------------------------------------
	// Stages 8-9: scale by the configured mean and range, add the offset
	// ------------------------------------------------------------------
	logic signed [31:0] pm_s8;
	logic signed [31:0] ph_s8;
	logic signed [33:0] acc_s9;
	logic signed [14:0] range_sx;

	assign range_sx = signed'({1'b0, range_q});

	always_ff @(posedge clk) begin
		if (run) begin
			pm_s8  <= 32'(dfc_pkg::MEAN_GAIN_Q16) * 32'(mean_q);
			ph_s8  <= 32'(h_s7) * 32'(range_sx);
			acc_s9 <= dfc_pkg::OFFSET_Q24 + 34'(pm_s8) + 34'(ph_s8);
		end
	end

	// round half up to Q8.8 and saturate
	logic signed [17:0]                 rnd;
	logic signed [dfc_pkg::TEMP_W-1:0]  res;

	always_comb begin
		rnd = 18'((acc_s9 + 34'sd32768) >>> 16);
		if (rnd > 18'sd32767) begin
			res = 16'sh7FFF;
		end else if (rnd < -18'sd32768) begin
			res = 16'sh8000;
		end else begin
			res = 16'(rnd);
		end
	end

	// ------------------------------------------------------------------
	// Output register and skid register.
	// A result leaving stage 9 goes to the output register when that is
	// free or being taken, else into the skid register, which then holds
	// the pipeline until the output transaction drains it.
	// ------------------------------------------------------------------
	logic                               leave;
	logic signed [dfc_pkg::TEMP_W-1:0]  out_q;
	logic signed [dfc_pkg::TEMP_W-1:0]  skid_q;

	assign leave = run && v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_vld_q     <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (leave) begin
			if (!result_valid_q || take) begin
				result_valid_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (leave) begin
			if (!result_valid_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign result_valid        = result_valid_q;
	assign surface_temperature = out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`DFT_ASSERT_IMPLY(a_skid_needs_out, skid_vld_q, result_valid_q, "skid full with output empty")
	`DFT_ASSERT_NEXT(a_skid_fills, leave && result_valid_q && result_stall, skid_vld_q, "result dropped on stalled output")
	`DFT_ASSERT_NEXT(a_hold_when_full, skid_vld_q && result_stall, $stable(v_s9) && $stable(acc_s9), "pipeline moved while full")
	`DFT_ASSERT_NEXT(a_mean_write, cfg_valid && cfg_ready && (cfg_index == dfc_pkg::REG_MEAN), mean_q == $past(cfg_data), "mean register write lost")

endmodule

`default_nettype wire

// ----- rtl/dfc_cordic.sv -----
// Two-lane pipelined rotation-mode CORDIC with quadrant fix-up.
`default_nettype none

module dfc_cordic #(
	parameter int STAGES = dfc_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_vld,
	input  wire dfc_pkg::angle_t [1:0]    angle,
	output logic                          out_vld,
	output dfc_pkg::trig_t [1:0]          trig
);

	localparam int NSTG = (STAGES < dfc_pkg::ATAN_ENTRIES) ? STAGES : dfc_pkg::ATAN_ENTRIES;

	logic                                  vld_s  [NSTG+1];
	logic signed [dfc_pkg::TRIG_W-1:0]     x_s    [NSTG+1][2];
	logic signed [dfc_pkg::TRIG_W-1:0]     y_s    [NSTG+1][2];
	logic signed [dfc_pkg::ANGLE_W-1:0]    z_s    [NSTG+1][2];
	dfc_pkg::quad_t                        quad_s [NSTG+1][2];
	logic                                  out_vld_q;
	dfc_pkg::trig_t [1:0]                  trig_q;

	// valid bits advance with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSTG; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= NSTG; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			out_vld_q <= vld_s[NSTG];
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[0][l]    <= dfc_pkg::CORDIC_GAIN_Q30;
				y_s[0][l]    <= '0;
				z_s[0][l]    <= angle[l].z;
				quad_s[0][l] <= angle[l].quad;
			end
		end

		for (genvar k = 0; k < NSTG; k++) begin : g_iter
			// rotate toward zero residual angle
			always_ff @(posedge clk) begin
				if (en) begin
					if (z_s[k][l] >= 0) begin
						x_s[k+1][l] <= x_s[k][l] - (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] + (x_s[k][l] >>> k);
						z_s[k+1][l] <= z_s[k][l] - dfc_pkg::atan_q30(5'(k));
					end else begin
						x_s[k+1][l] <= x_s[k][l] + (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] - (x_s[k][l] >>> k);
						z_s[k+1][l] <= z_s[k][l] + dfc_pkg::atan_q30(5'(k));
					end
					quad_s[k+1][l] <= quad_s[k][l];
				end
			end
		end

		// map the octant result back onto the full circle
		always_ff @(posedge clk) begin
			if (en) begin
				case (quad_s[NSTG][l])
					dfc_pkg::QUAD_0: begin
						trig_q[l].c <= x_s[NSTG][l];
						trig_q[l].s <= y_s[NSTG][l];
					end
					dfc_pkg::QUAD_90: begin
						trig_q[l].c <= -y_s[NSTG][l];
						trig_q[l].s <= x_s[NSTG][l];
					end
					dfc_pkg::QUAD_180: begin
						trig_q[l].c <= -x_s[NSTG][l];
						trig_q[l].s <= -y_s[NSTG][l];
					end
					default: begin
						trig_q[l].c <= y_s[NSTG][l];
						trig_q[l].s <= -x_s[NSTG][l];
					end
				endcase
			end
		end
	end

	assign out_vld = out_vld_q;
	assign trig    = trig_q;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the diurnal Fourier temperature unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

	// Keep the stage count in one place so the predictor and the block agree.
	localparam int STAGES  = dfc_pkg::CORDIC_STAGES_DEF;
	localparam int LATENCY = ((STAGES < 24) ? STAGES : 24) + 12;

	// Spare register indexes; writes to them must leave the model unchanged.
	localparam logic [dfc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [dfc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam logic [16:0] DAY_LEN = 17'd86400;

	// Fixed coefficients of the series: offset in Q24, gains and weights in Q16, pi/2 and CORDIC gain in Q30.
	localparam longint OFFSET_Q24    = -64'sd5505443;
	localparam longint MEAN_GAIN_Q16 = 64'sd63303;
	localparam longint COS1_Q16      = -64'sd28509;
	localparam longint SIN1_Q16      = -64'sd9472;
	localparam longint COS2_Q16      = 64'sd6550;
	localparam longint SIN2_Q16      = 64'sd1606;
	localparam longint PI_HALF_Q30   = 64'sd1686629713;
	localparam longint CORDIC_K_Q30  = 64'sd652032874;

	// Length of the deliberate output hold that backs the pipeline up.
	localparam int HOLD_CYCLES = 240;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [dfc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dfc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic sample_valid;
	logic sample_stall;
	logic [dfc_pkg::TIME_W-1:0] time_seconds;
	logic result_valid;
	logic result_stall;
	logic signed [dfc_pkg::TEMP_W-1:0] surface_temperature;

	// Predictor copy of the two configuration registers.
	logic signed [dfc_pkg::MEAN_W-1:0] mean_setting;
	logic [dfc_pkg::RANGE_W-1:0] range_setting;

	// Temperatures still owed by the block, oldest first.
	logic signed [dfc_pkg::TEMP_W-1:0] expected_temps[$];
	int mismatch_count;

	// Handshake between the hold-off test and the receiver process.
	bit hold_request;
	bit hold_active;

	diurnal_fourier_temperature_unit #(
		.CORDIC_STAGES(STAGES)
	) u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.sample_valid       (sample_valid),
		.sample_stall       (sample_stall),
		.time_seconds       (time_seconds),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.surface_temperature(surface_temperature)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous ceiling: several times the slowest legal run.
	initial begin : watchdog
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// atan(2^-i) in Q30 radians.
	function automatic longint cordic_angle(input int i);
		case (i)
			0:  return 64'sd843314856;
			1:  return 64'sd497837829;
			2:  return 64'sd263043836;
			3:  return 64'sd133525158;
			4:  return 64'sd67021686;
			5:  return 64'sd33543515;
			6:  return 64'sd16775850;
			7:  return 64'sd8388437;
			8:  return 64'sd4194282;
			9:  return 64'sd2097149;
			10: return 64'sd1048575;
			11: return 64'sd524287;
			12: return 64'sd262143;
			13: return 64'sd131071;
			14: return 64'sd65535;
			15: return 64'sd32767;
			16: return 64'sd16383;
			17: return 64'sd8191;
			18: return 64'sd4095;
			19: return 64'sd2047;
			20: return 64'sd1023;
			21: return 64'sd511;
			22: return 64'sd255;
			default: return 64'sd127;
		endcase
	endfunction

	// Cosine and sine (Q30) of a phase given as a 32-bit fraction of a turn.
	// Center the residual on the nearest quarter turn, rotate, then fold the
	// quadrant back in.
	function automatic void day_trig(input logic [31:0] phase, output longint cos_v,
			output longint sin_v);
		logic [31:0] shifted;
		dfc_pkg::quad_t quad;
		longint resid, z, x, y, dx, dy;
		int i;
		shifted = phase + 32'h2000_0000;
		quad = dfc_pkg::quad_t'(shifted[31:30]);
		resid = longint'({2'b00, shifted[29:0]}) - 64'sd536870912;
		// signed division truncates toward zero
		z = (resid * PI_HALF_Q30) / 64'sd1073741824;
		x = CORDIC_K_Q30;
		y = 0;
		for (i = 0; i < STAGES && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - cordic_angle(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + cordic_angle(i);
			end
		end
		case (quad)
			dfc_pkg::QUAD_0: begin
				cos_v = x;
				sin_v = y;
			end
			dfc_pkg::QUAD_90: begin
				cos_v = -y;
				sin_v = x;
			end
			dfc_pkg::QUAD_180: begin
				cos_v = -x;
				sin_v = -y;
			end
			default: begin
				cos_v = y;
				sin_v = -x;
			end
		endcase
	endfunction

	function automatic logic signed [15:0] predict_surface_temperature(input logic [16:0] t_in);
		logic [16:0] t;
		logic [63:0] scaled;
		logic [31:0] p1, p2;
		longint c1, s1, c2, s2, harm_sum, harm, acc, rounded;
		t = t_in;
		// a value of one day or more wraps exactly once
		if (t >= DAY_LEN)
			t = t - DAY_LEN;
		scaled = {15'd0, t, 32'd0} / 64'd86400;
		p1 = scaled[31:0];
		p2 = {p1[30:0], 1'b0};
		day_trig(p1, c1, s1);
		day_trig(p2, c2, s2);
		harm_sum = COS1_Q16 * c1 + SIN1_Q16 * s1 + COS2_Q16 * c2 + SIN2_Q16 * s2;
		harm = (harm_sum + 64'sd536870912) >>> 30;
		acc = OFFSET_Q24 + MEAN_GAIN_Q16 * longint'(mean_setting)
			+ harm * longint'(range_setting);
		rounded = (acc + 64'sd32768) >>> 16;
		if (rounded > 32767)
			rounded = 32767;
		else if (rounded < -32768)
			rounded = -32768;
		return rounded[15:0];
	endfunction

	// ------------------------------------------------------------------
	// Random picks
	// ------------------------------------------------------------------

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly in-day times, a good share past midnight, some right at the
	// octant boundaries where the quadrant reduction switches.
	function automatic logic [16:0] random_time();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 17'($urandom_range(0, 86399));
		if (roll < 85)
			return 17'($urandom_range(86400, 131071));
		return 17'(10800 * $urandom_range(0, 12) + $urandom_range(0, 2));
	endfunction

	// Mean: nominal span, raw 15-bit patterns, or the extremes.
	function automatic int pick_mean();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return int'($urandom_range(0, 25600)) - 12800;
		if (roll < 80)
			return int'($urandom_range(0, 32767));
		case ($urandom_range(0, 3))
			0: return -16384;
			1: return 16383;
			2: return -12800;
			default: return 12800;
		endcase
	endfunction

	// Range: nominal span, sometimes with the unused top data bit set.
	function automatic int pick_range();
		int roll, val;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			val = $urandom_range(0, 12800);
			if ($urandom_range(0, 3) == 0)
				val = val + 16384;
			return val;
		end
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 12800;
			default: return 16383;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one time sample after an optional gap; hold it until taken, then
	// log the temperature it must produce.
	task automatic send_sample(input logic [16:0] t, input int idle_len);
		if (idle_len > 0) begin
			sample_valid <= 1'b0;
			repeat (idle_len) @(posedge clk);
		end
		sample_valid <= 1'b1;
		time_seconds <= t;
		do @(posedge clk); while (sample_stall);
		expected_temps.push_back(predict_surface_temperature(t));
	endtask

	// Drop valid, let every owed result come out, then allow the pipeline
	// to empty fully.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (expected_temps.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Raise a config write and hold it until the block takes it. Valid is
	// left high so back-to-back writes never toggle it within one step.
	task automatic write_register(input logic [dfc_pkg::CFG_IDX_W-1:0] idx,
			input logic [dfc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			dfc_pkg::REG_MEAN:  mean_setting = data;
			dfc_pkg::REG_RANGE: range_setting = data[13:0];
			default: ;
		endcase
	endtask

	// Reprogram both registers while idle, optionally interleaving writes to
	// the spare indexes that must be ignored.
	task automatic configure(input int mean_val, input int range_val, input bit with_spare);
		logic [dfc_pkg::CFG_DATA_W-1:0] spare_data;
		spare_data = 15'($urandom_range(0, 32767));
		wait_idle();
		write_register(dfc_pkg::REG_MEAN, mean_val[14:0]);
		if (with_spare)
			write_register(REG_SPARE_A, spare_data);
		write_register(dfc_pkg::REG_RANGE, range_val[14:0]);
		if (with_spare)
			write_register(REG_SPARE_B, ~spare_data);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver pacing: random stall runs, plus one long hold on request
	// ------------------------------------------------------------------
	initial begin : receiver_pacing
		int run_len, stall_len, held;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				// hold the output long enough for the pipeline and skid
				// register to fill and push back on the sample side
				hold_request = 1'b0;
				hold_active = 1'b1;
				result_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_active = 1'b0;
			end
			result_stall <= 1'b0;
			run_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			repeat (run_len) @(posedge clk);
			stall_len = pick_idle_len();
			if (stall_len > 0) begin
				result_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every transaction on the result side against the
	// oldest owed temperature
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		logic signed [dfc_pkg::TEMP_W-1:0] want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_temps.size() == 0) begin
				$error("surface_temperature: no transaction expected, actual %0d",
					surface_temperature);
				mismatch_count++;
			end else begin
				want = expected_temps.pop_front();
				if (surface_temperature !== want) begin
					$error("surface_temperature: expected %0d, actual %0d",
						want, surface_temperature);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Registers at their reset value: the result is the fixed offset alone.
	task automatic test_reset_defaults();
		send_sample(17'd0, 0);
		send_sample(17'd43200, 0);
		send_sample(17'd131071, 1);
	endtask

	// Day boundaries, quarter and octant points, wrap past midnight, and
	// alternating bit patterns on the time field.
	task automatic test_time_corners();
		configure(2560, 2560, 1'b0);
		send_sample(17'd0, 0);
		send_sample(17'd1, 0);
		send_sample(17'd10799, 2);
		send_sample(17'd10800, 0);
		send_sample(17'd21600, 0);
		send_sample(17'd43200, 1);
		send_sample(17'd64800, 0);
		send_sample(17'd86399, 0);
		send_sample(17'd86400, 0);
		send_sample(17'd86401, 3);
		send_sample(17'd131071, 0);
		send_sample(17'h15555, 0);
		send_sample(17'h0AAAA, 0);
	endtask

	// Register extremes, out-of-span values, the ignored top range bit and
	// writes to the spare indexes.
	task automatic test_register_extremes();
		configure(-16384, 16383, 1'b1);
		send_sample(17'd21600, 0);
		send_sample(17'd64800, 0);
		configure(16383, 32767, 1'b0);
		send_sample(17'd21600, 0);
		send_sample(17'd50000, 0);
		configure(-12800, 0, 1'b1);
		send_sample(17'd30000, 0);
		send_sample(17'd100000, 0);
		configure(12800, 12800, 1'b0);
		send_sample(17'd54000, 0);
		send_sample(17'd7200, 0);
	endtask

	// Hold the output for a long stretch while samples keep coming back to
	// back, so the block must stall its input; then let it drain completely.
	task automatic test_output_backpressure();
		int n;
		configure(pick_mean(), pick_range(), 1'b0);
		hold_request = 1'b1;
		while (!hold_active)
			@(posedge clk);
		for (n = 0; n < 120; n++)
			send_sample(random_time(), 0);
		wait_idle();
	endtask

	// Random days under a series of settings; some phases run with no gaps.
	task automatic test_random_days();
		int phase_idx, n;
		bit paced;
		for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
			configure(pick_mean(), pick_range(), phase_idx == 3);
			paced = (phase_idx % 3) != 1;
			for (n = 0; n < 120; n++)
				send_sample(random_time(), paced ? pick_idle_len() : 0);
		end
		wait_idle();
	endtask

	initial begin : main_sequence
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_valid = 1'b0;
		time_seconds = '0;
		result_stall = 1'b0;
		mean_setting = '0;
		range_setting = '0;
		mismatch_count = 0;
		hold_request = 1'b0;
		hold_active = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_time_corners();
		test_register_extremes();
		test_output_backpressure();
		test_random_days();
		wait_idle();

		if (mismatch_count == 0 && expected_temps.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
